// ----- rtl/smst_pkg.sv -----
`default_nettype none

package smst_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_CLEARED  = 2'd2
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   localparam logic [8:0]  CAPACITY_RESET = 9'd100;
   localparam logic [31:0] GAP_NONE       = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/smst_store.sv -----
`default_nettype none

module smst_store #(
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                    clock,
   input  wire smst_pkg::store_ctl_type ctl,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire logic [31:0]             wr_data,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output logic [31:0]                  rd_data
);
   import smst_pkg::*;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/set_min_max_span_tracker_unit.sv -----
`default_nettype none

// Set min/max span tracker. A request is taken when start is high and busy is
// low; busy then stays high until the result strobe rsp_valid, which lasts one
// cycle and cannot be held off by the receiver. A clear, a rejected insert and
// an insert into an empty store go straight to the finish state; an insert
// into a store holding values first runs a scan that reads each held value
// from the value memory, one per cycle, to update the shortest span. The user
// must write Capacity (offset 0) only while idle; the block itself does not enforce it.
module set_min_max_span_tracker_unit #(
   parameter int DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_count,
   output logic             rsp_has_span,
   output logic [31:0]      rsp_shortest_span,
   output logic [31:0]      rsp_longest_span,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import smst_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic [31:0]       value_ff;
   logic [CNT_W-1:0]  iss_ff;
   logic              rd_vld_ff;
   logic [CNT_W-1:0]  held_count_ff, held_count_in;
   logic [31:0]       least_ff, least_in;
   logic [31:0]       greatest_ff, greatest_in;
   logic [31:0]       best_gap_ff, best_gap_in;
   logic [8:0]        capacity_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [8:0]        rsp_count_ff, rsp_count_in;
   logic              rsp_has_span_ff, rsp_has_span_in;
   logic [31:0]       rsp_shortest_ff, rsp_shortest_in;
   logic [31:0]       rsp_longest_ff, rsp_longest_in;

   logic              accept;
   logic              full;
   logic              scan_rd;
   logic              finishing;
   store_ctl_type     store_ctl;
   logic [31:0]       rd_data;
   logic [31:0]       gap;
   logic [31:0]       cap_ext, limit;
   logic [31:0]       cnt_ext;
   logic              csr_wr;

   smst_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (held_count_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_addr (iss_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign accept  = start && !busy;
   assign cap_ext = 32'(capacity_ff);
   assign limit   = (cap_ext < 32'(DEPTH)) ? cap_ext : 32'(DEPTH);
   assign full    = 32'(held_count_ff) >= limit;
   assign gap     = ($signed(value_ff) >= $signed(rd_data)) ? (value_ff - rd_data)
                                                            : (rd_data - value_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CLEAR || full || held_count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (iss_ff == held_count_ff && !rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy            = (state_ff != ST_IDLE);
      finishing       = (state_ff == ST_FINISH);
      scan_rd         = (state_ff == ST_SCAN) && (iss_ff != held_count_ff);
      store_ctl.rd_en = scan_rd;
      store_ctl.wr_en = finishing && cmd_ff == CMD_INSERT && !full;
   end

   always_comb begin
      held_count_in = held_count_ff;
      least_in      = least_ff;
      greatest_in   = greatest_ff;
      best_gap_in   = best_gap_ff;
      rsp_status_in = STATUS_INSERTED;
      if (rd_vld_ff && gap < best_gap_ff) begin
         best_gap_in = gap;
      end
      if (finishing) begin
         priority if (cmd_ff == CMD_CLEAR) begin
            held_count_in = '0;
            least_in      = '0;
            greatest_in   = '0;
            best_gap_in   = GAP_NONE;
            rsp_status_in = STATUS_CLEARED;
         end else if (full) begin
            rsp_status_in = STATUS_REJECTED;
         end else begin
            held_count_in = held_count_ff + CNT_W'(1);
            if (held_count_ff == '0) begin
               least_in    = value_ff;
               greatest_in = value_ff;
            end else begin
               if ($signed(value_ff) < $signed(least_ff)) begin
                  least_in = value_ff;
               end
               if ($signed(value_ff) > $signed(greatest_ff)) begin
                  greatest_in = value_ff;
               end
            end
         end
      end
      cnt_ext         = 32'(held_count_in);
      rsp_count_in    = cnt_ext[8:0];
      rsp_has_span_in = cnt_ext >= 32'd2;
      rsp_shortest_in = rsp_has_span_in ? best_gap_in : '0;
      rsp_longest_in  = rsp_has_span_in ? (greatest_in - least_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         held_count_ff <= '0;
         least_ff      <= '0;
         greatest_ff   <= '0;
         best_gap_ff   <= GAP_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= scan_rd;
         held_count_ff <= held_count_in;
         least_ff      <= least_in;
         greatest_ff   <= greatest_in;
         best_gap_ff   <= best_gap_in;
         rsp_valid_ff  <= finishing;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_cmd);
         value_ff <= req_value;
         iss_ff   <= '0;
      end else if (scan_rd) begin
         iss_ff <= iss_ff + CNT_W'(1);
      end
      if (finishing) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_has_span_ff <= rsp_has_span_in;
         rsp_shortest_ff <= rsp_shortest_in;
         rsp_longest_ff  <= rsp_longest_in;
      end
   end

   // config: capacity at offset 0
   assign csr_wr = psel && penable && pwrite && pready && !paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr) begin
         capacity_ff <= pwdata[8:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(capacity_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_has_span      = rsp_has_span_ff;
   assign rsp_shortest_span = rsp_shortest_ff;
   assign rsp_longest_span  = rsp_longest_ff;

endmodule

`default_nettype wire

// ----- rtl/smst_checker.sv -----
`default_nettype none

module smst_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [8:0]  rsp_count,
   input wire logic        rsp_has_span,
   input wire logic [31:0] rsp_shortest_span,
   input wire logic [31:0] rsp_longest_span
);
   import smst_pkg::*;

   a_take_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but busy not raised");

   a_strobe_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $fell(busy))
      else $error("result strobe not aligned with end of busy");

   a_no_span_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_span) |-> (rsp_shortest_span == '0 && rsp_longest_span == '0))
      else $error("spans nonzero without span");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_CLEARED) |-> (rsp_count == '0 && !rsp_has_span))
      else $error("clear left values held");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_INSERTED || rsp_status == STATUS_REJECTED ||
                     rsp_status == STATUS_CLEARED))
      else $error("bad status code");

endmodule

bind set_min_max_span_tracker_unit smst_checker u_smst_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_count         (rsp_count),
   .rsp_has_span      (rsp_has_span),
   .rsp_shortest_span (rsp_shortest_span),
   .rsp_longest_span  (rsp_longest_span)
);

`default_nettype wire

// ----- test/set_min_max_span_tracker_unit_tb.sv -----
`timescale 1ns / 1ps

module set_min_max_span_tracker_unit_tb;
   import smst_pkg::*;

   localparam int DEPTH = 256;
   localparam logic [2:0] CAPACITY_ADDR = 3'd0;

   typedef struct {
      status_type  status;
      logic [8:0]  count;
      logic        has_span;
      logic [31:0] shortest;
      logic [31:0] longest;
   } span_report_type;

   class span_scoreboard;
      logic [31:0]     held_values[$];
      logic [31:0]     least;
      logic [31:0]     greatest;
      logic [31:0]     best_gap;
      logic [8:0]      capacity;
      span_report_type expected_reports[$];
      int unsigned     errors;

      function new();
         capacity = CAPACITY_RESET;
         errors = 0;
         clear_store();
      endfunction

      function void clear_store();
         held_values.delete();
         least = '0;
         greatest = '0;
         best_gap = GAP_NONE;
      endfunction

      function int unsigned store_limit();
         return (capacity < DEPTH) ? capacity : DEPTH;
      endfunction

      function void note_request(cmd_type cmd, logic [31:0] value);
         span_report_type r;
         logic [31:0]     gap;
         status_type      st;
         if (cmd == CMD_CLEAR) begin
            clear_store();
            st = STATUS_CLEARED;
         end else if (held_values.size() >= store_limit()) begin
            st = STATUS_REJECTED;
         end else begin
            foreach (held_values[i]) begin
               gap = ($signed(value) >= $signed(held_values[i])) ?
                     value - held_values[i] : held_values[i] - value;
               if (gap < best_gap) best_gap = gap;
            end
            if (held_values.size() == 0) begin
               least = value;
               greatest = value;
            end else begin
               if ($signed(value) < $signed(least)) least = value;
               if ($signed(value) > $signed(greatest)) greatest = value;
            end
            held_values.push_back(value);
            st = STATUS_INSERTED;
         end
         r.status   = st;
         r.count    = 9'(held_values.size());
         r.has_span = held_values.size() >= 2;
         r.shortest = r.has_span ? best_gap : 32'd0;
         r.longest  = r.has_span ? greatest - least : 32'd0;
         expected_reports.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [8:0] count, logic has_span,
                                 logic [31:0] shortest, logic [31:0] longest);
         span_report_type r;
         if (expected_reports.size() == 0) begin
            $error("result strobe with no request pending");
            errors++;
            return;
         end
         r = expected_reports.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            errors++;
         end
         if (count !== r.count) begin
            $error("count: expected %0d, got %0d", r.count, count);
            errors++;
         end
         if (has_span !== r.has_span) begin
            $error("has_span: expected %0d, got %0d", r.has_span, has_span);
            errors++;
         end
         if (shortest !== r.shortest) begin
            $error("shortest_span: expected %h, got %h", r.shortest, shortest);
            errors++;
         end
         if (longest !== r.longest) begin
            $error("longest_span: expected %h, got %h", r.longest, longest);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [8:0]  rsp_count;
   logic        rsp_has_span;
   logic [31:0] rsp_shortest_span;
   logic [31:0] rsp_longest_span;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   span_scoreboard sb = new();
   int unsigned    idle_pct;

   set_min_max_span_tracker_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_has_span(rsp_has_span),
      .rsp_shortest_span(rsp_shortest_span),
      .rsp_longest_span(rsp_longest_span),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_count, rsp_has_span, rsp_shortest_span,
                         rsp_longest_span);
   end

   task automatic send_request(input cmd_type cmd, input logic [31:0] value);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(cmd, value);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.expected_reports.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic check_capacity(input logic [8:0] expected);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CAPACITY_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {23'd0, expected}) begin
         $error("capacity: expected %0d, got %0d", expected, prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_capacity(input logic [8:0] cap);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= {23'd0, cap};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.capacity = cap;
      check_capacity(cap);
   endtask

   // mix of extremes, near neighbors and duplicates of held values
   function automatic logic [31:0] pick_value();
      int unsigned n;
      n = sb.held_values.size();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: return $urandom();
         5, 6: if (n != 0) return sb.held_values[$urandom_range(n - 1)] + $urandom_range(16) - 8;
         7: if (n != 0) return sb.held_values[$urandom_range(n - 1)];
         default: ;
      endcase
      return $urandom_range(64) - 32;
   endfunction

   task automatic run_phase(input logic [8:0] cap, input int unsigned idle,
                            input int unsigned items, input int unsigned clear_pct);
      cmd_type cmd;
      wait_drained();
      set_capacity(cap);
      idle_pct = idle;
      repeat (items) begin
         if (sb.held_values.size() >= sb.store_limit())
            cmd = ($urandom_range(99) < 40) ? CMD_CLEAR : CMD_INSERT;
         else
            cmd = ($urandom_range(99) < clear_pct) ? CMD_CLEAR : CMD_INSERT;
         send_request(cmd, pick_value());
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_cmd   <= CMD_INSERT;
      req_value <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= CAPACITY_ADDR;
      pwdata    <= '0;
      idle_pct  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_capacity(CAPACITY_RESET);

      send_request(CMD_INSERT, 32'd0);
      send_request(CMD_INSERT, 32'h8000_0000);
      send_request(CMD_INSERT, 32'h7FFF_FFFF);
      send_request(CMD_INSERT, 32'h7FFF_FFFF);
      send_request(CMD_CLEAR, 32'hFFFF_FFFF);
      send_request(CMD_CLEAR, 32'd0);
      send_request(CMD_INSERT, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 32'd1);
      send_request(CMD_INSERT, 32'hFFFF_FFFF);

      // capacity dropped below the held count
      wait_drained();
      set_capacity(9'd2);
      send_request(CMD_INSERT, 32'd5);
      send_request(CMD_CLEAR, 32'd0);
      send_request(CMD_INSERT, 32'd10);
      send_request(CMD_INSERT, 32'd20);
      send_request(CMD_INSERT, 32'd30);

      wait_drained();
      set_capacity(9'd0);
      send_request(CMD_INSERT, 32'd1);
      send_request(CMD_CLEAR, 32'd0);
      send_request(CMD_INSERT, 32'd1);

      // above DEPTH saturates
      wait_drained();
      set_capacity(9'd511);
      send_request(CMD_INSERT, 32'h8000_0000);
      send_request(CMD_INSERT, 32'h7FFF_FFFF);
      send_request(CMD_CLEAR, 32'd0);

      run_phase(9'd100, 0, 120, 4);
      run_phase(9'($urandom_range(20, 2)), 77, 120, 6);
      run_phase(9'd1, 26, 40, 10);
      run_phase(9'd511, 0, 250, 0);
      run_phase(9'($urandom_range(256)), 77, 100, 3);
      run_phase(9'd255, 26, 100, 3);

      wait_drained();
      repeat (300) @(posedge clock);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
